// File: rtl/u8d_pkg.sv
// Shared widths, constants and the lead-byte decode function for the UTF-8 stream decoder.
// No dependencies; used by the channel interfaces and the top level.
package u8d_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned CODE_W   = 32;
    localparam int unsigned LEN_W    = 4;
    localparam int unsigned LEFT_W   = 3;
    localparam int unsigned LOW6_W   = 6;

    localparam logic [BYTE_W-1:0] LOW6_MASK = 8'h3f;

    // Count leading one bits of a byte, 0 to 8.
    function automatic logic [LEN_W-1:0] count_leading_ones(input logic [BYTE_W-1:0] b);
        logic [LEN_W-1:0] n;
        logic             run;
        n   = '0;
        run = 1'b1;
        for (int i = BYTE_W - 1; i >= 0; i--)
        begin
            run = run & b[i];
            n   = n + LEN_W'(run);
        end
        return n;
    endfunction

endpackage

// File: rtl/u8d_byte_if.sv
// Byte channel: valid/ready handshake carrying one raw byte and its final flag.
// Depends on u8d_pkg.
interface u8d_byte_if;
    import u8d_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              final_byte;

    modport source (output valid, output data_byte, output final_byte, input ready);
    modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

// File: rtl/u8d_code_if.sv
// Code point channel: valid/ready handshake carrying one decoded sequence.
// Depends on u8d_pkg.
interface u8d_code_if;
    import u8d_pkg::*;

    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] code_point;
    logic [LEN_W-1:0]  seq_length;
    logic              truncated;

    modport source (output valid, output code_point, output seq_length, output truncated,
                    input ready);
    modport sink   (input valid, input code_point, input seq_length, input truncated,
                    output ready);
endinterface

// File: rtl/utf8_stream_decoder.sv
// Top level of the UTF-8 stream decoder: sequence state and the result register.
// Depends on u8d_pkg, u8d_byte_if and u8d_code_if.
//
// The decoder takes one byte per cycle and emits one code point per completed
// sequence, or a truncated result when the final flag falls inside a sequence.
// Each byte is decoded by a leading-ones count, a 6-bit shift and a mask into
// the accumulator in the same cycle it is transferred; the result is then
// registered into the output register. That register holds a finished result
// while the next byte is transferred, so the input stalls only when a result
// waits and the downstream side does not take it. Sustained rate: one byte
// per cycle. No reset sweep: the block is ready right after reset.
module utf8_stream_decoder (
    input  logic       clk,
    input  logic       rst_n,
    u8d_byte_if.sink   stream,
    u8d_code_if.source codes
);
    import u8d_pkg::*;

    logic [LEFT_W-1:0] bytes_left_reg,  bytes_left_next;
    logic [LEN_W-1:0]  seq_total_reg,   seq_total_next;
    logic [CODE_W-1:0] accumulator_reg, accumulator_next;

    logic              out_valid_reg,   out_valid_next;
    logic [CODE_W-1:0] code_point_reg,  code_point_next;
    logic [LEN_W-1:0]  seq_length_reg,  seq_length_next;
    logic              truncated_reg,   truncated_next;

    logic              in_xfer;
    logic              emit;
    logic [LEN_W-1:0]  lead_ones;
    logic [CODE_W-1:0] acc_shifted;
    logic [LEFT_W-1:0] left_dec;

    assign stream.ready = !out_valid_reg || codes.ready;
    assign in_xfer      = stream.valid && stream.ready;

    assign lead_ones   = count_leading_ones(stream.data_byte);
    assign acc_shifted = {accumulator_reg[CODE_W-LOW6_W-1:0], stream.data_byte[LOW6_W-1:0]};
    assign left_dec    = bytes_left_reg - LEFT_W'(1);

    always_comb
    begin
        bytes_left_next  = bytes_left_reg;
        seq_total_next   = seq_total_reg;
        accumulator_next = accumulator_reg;
        emit             = 1'b0;
        code_point_next  = code_point_reg;
        seq_length_next  = seq_length_reg;
        truncated_next   = truncated_reg;

        if (in_xfer)
        begin
            if (bytes_left_reg == '0)
            begin
                if (lead_ones == '0)
                begin
                    emit            = 1'b1;
                    code_point_next = CODE_W'(stream.data_byte);
                    seq_length_next = LEN_W'(1);
                    truncated_next  = 1'b0;
                end
                else if (lead_ones == LEN_W'(1))
                begin
                    emit            = 1'b1;
                    code_point_next = CODE_W'(stream.data_byte & LOW6_MASK);
                    seq_length_next = LEN_W'(1);
                    truncated_next  = 1'b0;
                end
                else
                begin
                    accumulator_next = CODE_W'(stream.data_byte & (8'hff >> lead_ones));
                    seq_total_next   = lead_ones;
                    bytes_left_next  = LEFT_W'(lead_ones - LEN_W'(1));
                    if (stream.final_byte)
                    begin
                        emit            = 1'b1;
                        code_point_next = '0;
                        seq_length_next = LEN_W'(1);
                        truncated_next  = 1'b1;
                    end
                end
            end
            else
            begin
                accumulator_next = acc_shifted;
                bytes_left_next  = left_dec;
                if (left_dec == '0)
                begin
                    emit            = 1'b1;
                    code_point_next = acc_shifted;
                    seq_length_next = seq_total_reg;
                    truncated_next  = 1'b0;
                end
                else if (stream.final_byte)
                begin
                    emit            = 1'b1;
                    code_point_next = '0;
                    seq_length_next = seq_total_reg - LEN_W'(left_dec);
                    truncated_next  = 1'b1;
                end
            end

            // clear sequence state after every result
            if (emit)
            begin
                bytes_left_next  = '0;
                seq_total_next   = '0;
                accumulator_next = '0;
            end
        end

        if (emit)
            out_valid_next = 1'b1;
        else if (codes.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_left_reg  <= '0;
            seq_total_reg   <= '0;
            accumulator_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            bytes_left_reg  <= bytes_left_next;
            seq_total_reg   <= seq_total_next;
            accumulator_reg <= accumulator_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_point_reg <= code_point_next;
        seq_length_reg <= seq_length_next;
        truncated_reg  <= truncated_next;
    end

    assign codes.valid      = out_valid_reg;
    assign codes.code_point = code_point_reg;
    assign codes.seq_length = seq_length_reg;
    assign codes.truncated  = truncated_reg;

endmodule

// File: bench/utf8_stream_decoder_test.sv
// Self-checking bench for utf8_stream_decoder: byte stream in, decoded code points out.
// Depends on u8d_pkg, u8d_byte_if, u8d_code_if and the decoder RTL.
`timescale 1ns / 100ps

module utf8_stream_decoder_test;
    import u8d_pkg::*;

    typedef struct {
        logic [CODE_W-1:0] code_point;
        logic [LEN_W-1:0]  seq_length;
        logic              truncated;
    } code_result_t;

    logic clk;
    logic rst_n;

    u8d_byte_if stream_ch ();
    u8d_code_if code_ch ();

    utf8_stream_decoder u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (stream_ch),
        .codes  (code_ch)
    );

    code_result_t      pending_codes[$];
    int unsigned       failures;
    int unsigned       send_idle_pct;
    int unsigned       recv_stall_pct;

    logic [LEFT_W-1:0] cont_remaining;
    logic [LEN_W-1:0]  seq_bytes;
    logic [CODE_W-1:0] partial_code;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #(20_000_000);
        $display("tb: failure");
        $finish;
    end

    function automatic logic [LEN_W-1:0] lead_ones(input logic [BYTE_W-1:0] b);
        casez (b)
            8'b0???????: return 4'd0;
            8'b10??????: return 4'd1;
            8'b110?????: return 4'd2;
            8'b1110????: return 4'd3;
            8'b11110???: return 4'd4;
            8'b111110??: return 4'd5;
            8'b1111110?: return 4'd6;
            8'b11111110: return 4'd7;
            default:     return 4'd8;
        endcase
    endfunction

    task automatic retire_sequence(input logic [CODE_W-1:0] code, input logic [LEN_W-1:0] len,
                                   input logic trunc);
        code_result_t r;
        begin
            r.code_point = code;
            r.seq_length = len;
            r.truncated  = trunc;
            pending_codes.push_back(r);
            cont_remaining = '0;
            seq_bytes      = '0;
            partial_code   = '0;
        end
    endtask

    task automatic decode_byte(input logic [BYTE_W-1:0] b, input logic fin);
        logic [LEN_W-1:0] ones;
        begin
            ones = lead_ones(b);
            if (cont_remaining == '0)
            begin
                if (ones == 4'd0)
                    retire_sequence(CODE_W'(b), 4'd1, 1'b0);
                else if (ones == 4'd1)
                    retire_sequence(CODE_W'(b & LOW6_MASK), 4'd1, 1'b0);
                else
                begin
                    partial_code   = CODE_W'(b & (8'hFF >> ones));
                    seq_bytes      = ones;
                    cont_remaining = LEFT_W'(ones - 4'd1);
                    if (fin)
                        retire_sequence('0, 4'd1, 1'b1);
                end
            end
            else
            begin
                partial_code   = (partial_code << LOW6_W) + CODE_W'(b & LOW6_MASK);
                cont_remaining = cont_remaining - LEFT_W'(1);
                if (cont_remaining == '0)
                    retire_sequence(partial_code, seq_bytes, 1'b0);
                else if (fin)
                    retire_sequence('0, seq_bytes - LEN_W'(cont_remaining), 1'b1);
            end
        end
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic fin);
        while ($urandom_range(99, 0) < send_idle_pct)
        begin
            stream_ch.valid <= 1'b0;
            @(posedge clk);
        end
        stream_ch.valid      <= 1'b1;
        stream_ch.data_byte  <= b;
        stream_ch.final_byte <= fin;
        @(posedge clk);
        while (!stream_ch.ready)
            @(posedge clk);
        decode_byte(b, fin);
    endtask

    task automatic wait_drained();
        stream_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_codes.size() != 0);
    endtask

    always @(posedge clk)
        code_ch.ready <= rst_n && ($urandom_range(99, 0) >= recv_stall_pct);

    always @(posedge clk)
    begin : check_codes
        code_result_t want;
        if (rst_n && code_ch.valid && code_ch.ready)
        begin
            if (pending_codes.size() == 0)
            begin
                $error("unexpected transfer: code_point %h seq_length %0d truncated %0b",
                       code_ch.code_point, code_ch.seq_length, code_ch.truncated);
                failures++;
            end
            else
            begin
                want = pending_codes.pop_front();
                if (code_ch.code_point !== want.code_point)
                begin
                    $error("code_point expected %h actual %h", want.code_point,
                           code_ch.code_point);
                    failures++;
                end
                if (code_ch.seq_length !== want.seq_length)
                begin
                    $error("seq_length expected %0d actual %0d", want.seq_length,
                           code_ch.seq_length);
                    failures++;
                end
                if (code_ch.truncated !== want.truncated)
                begin
                    $error("truncated expected %0b actual %0b", want.truncated,
                           code_ch.truncated);
                    failures++;
                end
            end
        end
    end

    task automatic test_directed_cases();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hBF, 1'b1);
        // continuation byte is not checked
        send_byte(8'hC3, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(8'hE2, 1'b0);
        send_byte(8'h82, 1'b0);
        send_byte(8'hAC, 1'b1);
        // eight leading ones: seven followers, sum wraps
        for (int k = 0; k < 8; k++)
            send_byte(8'hFF, 1'b0);
        send_byte(8'hF8, 1'b1);
        send_byte(8'hF0, 1'b0);
        send_byte(8'h9F, 1'b1);
        wait_drained();
    endtask

    task automatic random_stream(input int unsigned target);
        int unsigned       sent;
        int unsigned       n;
        int unsigned       cut;
        logic              ends;
        logic [BYTE_W-1:0] b;
        begin
            sent = 0;
            while (sent < target)
            begin
                if ($urandom_range(9, 0) == 0)
                begin
                    send_byte(8'($urandom), $urandom_range(7, 0) == 0);
                    sent++;
                end
                else
                begin
                    n    = ($urandom_range(4, 0) < 2) ? 1 : $urandom_range(8, 2);
                    cut  = ($urandom_range(7, 0) == 0) ? $urandom_range(n, 1) : n;
                    ends = ($urandom_range(5, 0) == 0) || (cut < n);
                    for (int unsigned k = 0; k < cut; k++)
                    begin
                        if (k == 0 && n == 1)
                            b = 8'($urandom_range(8'hBF, 0));
                        else if (k == 0)
                            b = 8'(16'hFF00 >> n) | (8'($urandom) & (8'hFF >> (n + 1)));
                        else if ($urandom_range(9, 0) == 0)
                            b = 8'($urandom);
                        else
                            b = {2'b10, 6'($urandom)};
                        send_byte(b, ends && (k == cut - 1));
                        sent++;
                    end
                end
            end
            wait_drained();
        end
    endtask

    task automatic test_back_to_back();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        random_stream(460);
    endtask

    task automatic test_sender_gaps();
        send_idle_pct  = 77;
        recv_stall_pct = 0;
        random_stream(460);
    endtask

    task automatic test_receiver_stalls();
        send_idle_pct  = 0;
        recv_stall_pct = 77;
        random_stream(460);
    endtask

    task automatic test_both_idle();
        send_idle_pct  = 28;
        recv_stall_pct = 28;
        random_stream(460);
    endtask

    initial
    begin
        failures             = 0;
        send_idle_pct        = 0;
        recv_stall_pct       = 0;
        cont_remaining       = '0;
        seq_bytes            = '0;
        partial_code         = '0;
        rst_n                <= 1'b0;
        stream_ch.valid      <= 1'b0;
        stream_ch.data_byte  <= '0;
        stream_ch.final_byte <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        test_directed_cases();
        test_back_to_back();
        test_sender_gaps();
        test_receiver_stalls();
        test_both_idle();

        repeat (8) @(posedge clk);
        if (failures == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// File: utf8_stream_decoder.f
rtl/u8d_pkg.sv
rtl/u8d_byte_if.sv
rtl/u8d_code_if.sv
rtl/utf8_stream_decoder.sv
bench/utf8_stream_decoder_test.sv
